// ===== rtl/six_step_bldc_commutation_control_macros.svh =====
// Assertion helpers shared by the commutation controller RTL.
`ifndef SIX_STEP_BLDC_COMMUTATION_CONTROL_MACROS_SVH
`define SIX_STEP_BLDC_COMMUTATION_CONTROL_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SIXSTEP_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sixstep: invariant violated");

// Same-cycle implication.
`define SIXSTEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sixstep: implication violated");

// Next-cycle implication.
`define SIXSTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sixstep: next-cycle implication violated");

`endif

// ===== rtl/sixstep_pkg.sv =====
package sixstep_pkg;

    localparam int QUO_W       = 16;
    localparam int SUM_W       = 18;
    localparam int STOP_MARGIN = 30;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // event kinds
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_THROTTLE = 2'd1;
    localparam logic [1:0] FUNC_COMPARE  = 2'd2;
    localparam logic [1:0] FUNC_CURRENT  = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_NEUTRAL    = 3'd0;
    localparam logic [2:0] REG_PWM_TOP    = 3'd1;
    localparam logic [2:0] REG_CUR_LIMIT  = 3'd2;
    localparam logic [2:0] REG_START_DUTY = 3'd3;
    localparam logic [2:0] REG_FIRST_HOLD = 3'd4;
    localparam logic [2:0] REG_HOLD_DEC   = 3'd5;
    localparam logic [2:0] REG_STEPS      = 3'd6;

    localparam logic [15:0] RST_NEUTRAL    = 16'd3000;
    localparam logic [15:0] RST_PWM_TOP    = 16'd1200;
    localparam logic [11:0] RST_CUR_LIMIT  = 12'd3000;
    localparam logic [15:0] RST_START_DUTY = 16'd200;
    localparam logic [15:0] RST_FIRST_HOLD = 16'd3000;
    localparam logic [7:0]  RST_HOLD_DEC   = 8'd5;
    localparam logic [8:0]  RST_STEPS      = 9'd350;

    localparam logic [2:0] LAST_STEP = 3'd5;

    typedef struct packed {
        logic [15:0] neutral_width;
        logic [15:0] pwm_top;
        logic [11:0] current_limit;
        logic [15:0] startup_duty;
        logic [15:0] startup_first_hold;
        logic [7:0]  startup_hold_decrement;
        logic [8:0]  startup_steps;
    } cfg_t;

    // event fields carried down the throttle pipeline
    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  comparator;
        logic [11:0] current_sample;
        logic        big;   // throttle at or beyond full scale
        logic        zero;  // throttle at or below zero
    } tag_t;

    typedef struct packed {
        logic [2:0] high;
        logic [2:0] low;
        logic [2:0] watch;
    } gates_t;

    function automatic gates_t step_gates(input logic [2:0] s);
        gates_t g;
        case (s)
            3'd0:    g = '{high: 3'b001, low: 3'b100, watch: 3'b010};
            3'd1:    g = '{high: 3'b010, low: 3'b100, watch: 3'b001};
            3'd2:    g = '{high: 3'b010, low: 3'b001, watch: 3'b100};
            3'd3:    g = '{high: 3'b100, low: 3'b001, watch: 3'b010};
            3'd4:    g = '{high: 3'b100, low: 3'b010, watch: 3'b001};
            3'd5:    g = '{high: 3'b001, low: 3'b010, watch: 3'b100};
            default: g = '{high: 3'b001, low: 3'b100, watch: 3'b010};
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/sixstep_regs.sv =====
module sixstep_regs import sixstep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_width          <= RST_NEUTRAL;
            cfg_reg.pwm_top                <= RST_PWM_TOP;
            cfg_reg.current_limit          <= RST_CUR_LIMIT;
            cfg_reg.startup_duty           <= RST_START_DUTY;
            cfg_reg.startup_first_hold     <= RST_FIRST_HOLD;
            cfg_reg.startup_hold_decrement <= RST_HOLD_DEC;
            cfg_reg.startup_steps          <= RST_STEPS;
        end
        else if (wr_en)
        begin
            case (index)
                REG_NEUTRAL:    cfg_reg.neutral_width          <= pwdata[15:0];
                REG_PWM_TOP:    cfg_reg.pwm_top                <= pwdata[15:0];
                REG_CUR_LIMIT:  cfg_reg.current_limit          <= pwdata[11:0];
                REG_START_DUTY: cfg_reg.startup_duty           <= pwdata[15:0];
                REG_FIRST_HOLD: cfg_reg.startup_first_hold     <= pwdata[15:0];
                REG_HOLD_DEC:   cfg_reg.startup_hold_decrement <= pwdata[7:0];
                REG_STEPS:      cfg_reg.startup_steps          <= pwdata[8:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_NEUTRAL:    prdata = PDATA_W'(cfg_reg.neutral_width);
            REG_PWM_TOP:    prdata = PDATA_W'(cfg_reg.pwm_top);
            REG_CUR_LIMIT:  prdata = PDATA_W'(cfg_reg.current_limit);
            REG_START_DUTY: prdata = PDATA_W'(cfg_reg.startup_duty);
            REG_FIRST_HOLD: prdata = PDATA_W'(cfg_reg.startup_first_hold);
            REG_HOLD_DEC:   prdata = PDATA_W'(cfg_reg.startup_hold_decrement);
            REG_STEPS:      prdata = PDATA_W'(cfg_reg.startup_steps);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/sixstep_div.sv =====
module sixstep_div import sixstep_pkg::*;
#(
    parameter int SPAN = 6379
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tag_t                                in_tag,
    input  logic [$clog2(SPAN+1)+QUO_W-1:0]     in_prod,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tag_t                                out_tag,
    output logic [QUO_W-1:0]                    out_quo
);

    localparam int PW    = $clog2(SPAN+1) + QUO_W;
    localparam int RW    = PW + 1;
    localparam int SHIFT = PW + $clog2(SPAN);
    // ceil(2^SHIFT / SPAN) gives the exact floor quotient for any PW-bit dividend
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SHIFT) + 64'(SPAN) - 64'd1) / 64'(SPAN));

    logic              valid_reg;
    tag_t              tag_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [PW+RW-1:0]  full;
    logic [QUO_W-1:0]  quo_next;

    // dividend stays below SPAN * 2^16, so the quotient fits 16 bits
    assign full     = {{RW{1'b0}}, in_prod} * {{PW{1'b0}}, RECIP};
    assign quo_next = full[SHIFT +: QUO_W];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tag_reg <= in_tag;
            quo_reg <= quo_next;
        end
    end

endmodule

// ===== rtl/sixstep_pipe.sv =====
module sixstep_pipe import sixstep_pkg::*;
#(
    parameter int SPAN = 6379
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic [15:0]      pulse_width,
    input  logic [1:0]       comparator,
    input  logic [11:0]      current_sample,
    input  cfg_t             cfg,
    output logic             tail_valid,
    input  logic             tail_ready,
    output tag_t             tail_tag,
    output logic [QUO_W-1:0] tail_quo
);

    localparam int SW = $clog2(SPAN+1);
    localparam int PW = SW + QUO_W;
    localparam logic signed [SUM_W-1:0] SPAN_S = SUM_W'(SPAN);

    // stage A: offset throttle width
    logic signed [SUM_W-1:0] sum;
    logic                    a_valid_reg;
    logic                    a_ready;
    tag_t                    a_tag_reg;
    logic [SW-1:0]           a_sum_reg;

    // stage B: scale by PWM top
    logic                    b_valid_reg;
    logic                    b_ready;
    tag_t                    b_tag_reg;
    logic [PW-1:0]           b_prod_reg;
    logic [PW-1:0]           prod;

    logic                    div_ready;

    assign sum = $signed({2'b00, pulse_width}) - $signed({2'b00, cfg.neutral_width}) + SPAN_S;

    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_tag_reg.func           <= func;
            a_tag_reg.comparator     <= comparator;
            a_tag_reg.current_sample <= current_sample;
            a_tag_reg.big            <= sum >= SPAN_S;
            a_tag_reg.zero           <= sum[SUM_W-1] || (sum == '0);
            a_sum_reg                <= sum[SW-1:0];
        end
    end

    // only 0 < sum < SPAN gets here meaningfully, so the quotient fits 16 bits
    assign prod = (a_tag_reg.big || a_tag_reg.zero) ? '0
                : {{QUO_W{1'b0}}, a_sum_reg} * {{SW{1'b0}}, cfg.pwm_top};

    assign b_ready = !b_valid_reg || div_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_tag_reg  <= a_tag_reg;
            b_prod_reg <= prod;
        end
    end

    sixstep_div #(
        .SPAN (SPAN)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (div_ready),
        .in_tag    (b_tag_reg),
        .in_prod   (b_prod_reg),
        .out_valid (tail_valid),
        .out_ready (tail_ready),
        .out_tag   (tail_tag),
        .out_quo   (tail_quo)
    );

endmodule

// ===== rtl/sixstep_ctrl.sv =====
`include "six_step_bldc_commutation_control_macros.svh"

module sixstep_ctrl import sixstep_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  tag_t             in_tag,
    input  logic [QUO_W-1:0] in_quo,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       high_side_on,
    output logic [2:0]       low_side_on,
    output logic [2:0]       watch_mask,
    output logic [15:0]      duty,
    output logic [2:0]       step_index,
    output logic             moving,
    output logic             starting,
    output logic             over_current
);

    logic [2:0]  next_step_reg,  next_step_next;
    logic [2:0]  high_reg,       high_next;
    logic [2:0]  low_reg,        low_next;
    logic [2:0]  armed_reg,      armed_next;
    logic [15:0] duty_reg,       duty_next;
    logic        running_reg,    running_next;
    logic        ramping_reg,    ramping_next;
    logic [8:0]  ramp_count_reg, ramp_count_next;
    logic [15:0] hold_reg,       hold_next;
    logic [15:0] pending_reg,    pending_next;
    logic        limit_hold_reg, limit_hold_next;
    logic        out_valid_reg;

    logic                    accept;
    logic [15:0]             val;
    logic signed [SUM_W-1:0] stop_level;
    logic                    stop;
    logic [2:0]              cur_step;
    gates_t                  gates;
    logic [2:0]              step_after;
    logic [2:0]              cmp_mask;
    logic                    cmp_hit;
    logic [15:0]             hold_dec;
    logic [8:0]              count_inc;
    logic [8:0]              steps_eff;
    logic [16:0]             cut;
    logic [15:0]             hold_calc;
    logic [15:0]             first_hold;

    assign in_ready = !out_valid_reg || !out_stall;
    assign accept   = in_valid && in_ready;

    // throttle decision
    assign val        = in_tag.zero ? 16'd0 : in_quo;
    assign stop_level = $signed({2'b00, cfg.pwm_top}) - $signed(SUM_W'(STOP_MARGIN));
    assign stop       = in_tag.big || !($signed({2'b00, val}) < stop_level);

    // commutation table lookup
    assign cur_step   = (next_step_reg > LAST_STEP) ? 3'd0 : next_step_reg;
    assign gates      = step_gates(cur_step);
    assign step_after = (cur_step == LAST_STEP) ? 3'd0 : cur_step + 3'd1;

    assign cmp_mask = 3'b001 << in_tag.comparator;
    assign cmp_hit  = |(cmp_mask & armed_reg);

    // ramp pacing
    assign hold_dec   = (hold_reg == 16'd0) ? 16'd0 : hold_reg - 16'd1;
    assign count_inc  = ramp_count_reg + 9'd1;
    assign steps_eff  = (cfg.startup_steps == 9'd0) ? 9'd1 : cfg.startup_steps;
    assign cut        = {8'b0, count_inc} * {9'b0, cfg.startup_hold_decrement};
    assign hold_calc  = (cut >= {1'b0, cfg.startup_first_hold}) ? 16'd1
                      : cfg.startup_first_hold - cut[15:0];
    assign first_hold = (cfg.startup_first_hold == 16'd0) ? 16'd1
                      : cfg.startup_first_hold;

    always_comb
    begin
        next_step_next  = next_step_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        armed_next      = armed_reg;
        duty_next       = duty_reg;
        running_next    = running_reg;
        ramping_next    = ramping_reg;
        ramp_count_next = ramp_count_reg;
        hold_next       = hold_reg;
        pending_next    = pending_reg;
        limit_hold_next = limit_hold_reg;

        if (in_tag.func == FUNC_CURRENT)
        begin
            if (in_tag.current_sample > cfg.current_limit)
            begin
                low_next        = 3'b000;
                limit_hold_next = 1'b1;
            end
            else
            begin
                limit_hold_next = 1'b0;
            end
        end
        else if (!limit_hold_reg)
        begin
            case (in_tag.func)
                FUNC_TICK:
                begin
                    if (ramping_reg)
                    begin
                        hold_next = hold_dec;
                        if (hold_dec == 16'd0)
                        begin
                            ramp_count_next = count_inc;
                            if (count_inc >= steps_eff)
                            begin
                                ramping_next = 1'b0;
                                duty_next    = pending_reg;
                            end
                            else
                            begin
                                high_next      = gates.high;
                                low_next       = gates.low;
                                armed_next     = gates.watch;
                                next_step_next = step_after;
                                hold_next      = hold_calc;
                            end
                        end
                    end
                end
                FUNC_THROTTLE:
                begin
                    if (!ramping_reg)
                    begin
                        if (!stop)
                        begin
                            if (running_reg)
                            begin
                                duty_next = val;
                            end
                            else
                            begin
                                pending_next    = val;
                                running_next    = 1'b1;
                                ramping_next    = 1'b1;
                                ramp_count_next = 9'd0;
                                duty_next       = cfg.startup_duty;
                                high_next       = gates.high;
                                low_next        = gates.low;
                                armed_next      = gates.watch;
                                next_step_next  = step_after;
                                hold_next       = first_hold;
                            end
                        end
                        else
                        begin
                            running_next = 1'b0;
                            ramping_next = 1'b0;
                            duty_next    = cfg.pwm_top;
                        end
                    end
                end
                FUNC_COMPARE:
                begin
                    if (!ramping_reg && cmp_hit)
                    begin
                        high_next      = gates.high;
                        low_next       = gates.low;
                        armed_next     = gates.watch;
                        next_step_next = step_after;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_step_reg  <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            armed_reg      <= '0;
            duty_reg       <= '0;
            running_reg    <= 1'b0;
            ramping_reg    <= 1'b0;
            ramp_count_reg <= '0;
            hold_reg       <= '0;
            pending_reg    <= '0;
            limit_hold_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (accept)
            begin
                next_step_reg  <= next_step_next;
                high_reg       <= high_next;
                low_reg        <= low_next;
                armed_reg      <= armed_next;
                duty_reg       <= duty_next;
                running_reg    <= running_next;
                ramping_reg    <= ramping_next;
                ramp_count_reg <= ramp_count_next;
                hold_reg       <= hold_next;
                pending_reg    <= pending_next;
                limit_hold_reg <= limit_hold_next;
            end
        end
    end

    // state registers double as the result register
    assign out_valid    = out_valid_reg;
    assign high_side_on = high_reg;
    assign low_side_on  = low_reg;
    assign watch_mask   = armed_reg;
    assign duty         = duty_reg;
    assign moving       = running_reg;
    assign starting     = ramping_reg;
    assign over_current = limit_hold_reg;

    always_comb
    begin
        if (high_reg == 3'b000)
        begin
            step_index = 3'd0;
        end
        else if (next_step_reg == 3'd0 || next_step_reg > LAST_STEP)
        begin
            step_index = LAST_STEP;
        end
        else
        begin
            step_index = next_step_reg - 3'd1;
        end
    end

    `SIXSTEP_ASSERT(a_ramp_implies_run, clk, rst_n, !ramping_reg || running_reg)
    `SIXSTEP_ASSERT(a_no_shoot_through, clk, rst_n, (high_reg & low_reg) == 3'b000)
    `SIXSTEP_ASSERT_IMPL(a_hold_lows_off, clk, rst_n, limit_hold_reg, low_reg == 3'b000)
    `SIXSTEP_ASSERT_IMPL(a_one_armed, clk, rst_n, high_reg != 3'b000, $onehot(armed_reg))
    `SIXSTEP_ASSERT_NEXT(a_stalled_state, clk, rst_n, out_valid_reg && out_stall, $stable(duty_reg) && $stable(high_reg) && $stable(next_step_reg))

endmodule

// ===== rtl/six_step_bldc_commutation_control.sv =====
// Six-step sensorless BLDC commutation controller. Each request on the input
// channel is one event (1 us tick, throttle capture, back-EMF comparator
// edge, current sample) and produces exactly one result: gate enables, armed
// comparator, duty compare value, step index and run/ramp/overcurrent flags.
// The block takes one request per clock while in_stall is low; each request
// passes through the registered stages in order (input offset stage,
// throttle multiply stage, reciprocal-multiply division stage, then
// the state update that also holds the result). Empty stages collapse, so up
// to three more requests are taken while a result waits; then in_stall rises.
// Settings are written over the APB port at byte address 4*index and should
// only change while no request is in flight.
module six_step_bldc_commutation_control import sixstep_pkg::*;
#(
    parameter int THROTTLE_SPAN = 6379
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [15:0]        pulse_width,
    input  logic [1:0]         comparator,
    input  logic [11:0]        current_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         high_side_on,
    output logic [2:0]         low_side_on,
    output logic [2:0]         watch_mask,
    output logic [15:0]        duty,
    output logic [2:0]         step_index,
    output logic               moving,
    output logic               starting,
    output logic               over_current,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t             cfg;
    logic             tail_valid;
    logic             tail_ready;
    tag_t             tail_tag;
    logic [QUO_W-1:0] tail_quo;

    sixstep_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sixstep_pipe #(
        .SPAN (THROTTLE_SPAN)
    ) u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pulse_width    (pulse_width),
        .comparator     (comparator),
        .current_sample (current_sample),
        .cfg            (cfg),
        .tail_valid     (tail_valid),
        .tail_ready     (tail_ready),
        .tail_tag       (tail_tag),
        .tail_quo       (tail_quo)
    );

    sixstep_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (tail_valid),
        .in_ready     (tail_ready),
        .in_tag       (tail_tag),
        .in_quo       (tail_quo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .high_side_on (high_side_on),
        .low_side_on  (low_side_on),
        .watch_mask   (watch_mask),
        .duty         (duty),
        .step_index   (step_index),
        .moving       (moving),
        .starting     (starting),
        .over_current (over_current)
    );

endmodule

// ===== test/six_step_bldc_commutation_control_tb.sv =====
`timescale 1ns / 100ps

import sixstep_pkg::*;

localparam longint THROTTLE_COUNTS = 6379;

typedef struct packed {
    bit [2:0]  high;
    bit [2:0]  low;
    bit [2:0]  watch;
    bit [15:0] duty;
    bit [2:0]  step;
    bit        moving;
    bit        starting;
    bit        over_current;
} motor_out_t;

class commutation_scoreboard;
    bit [15:0]  neutral, top, start_duty, first_hold;
    bit [11:0]  limit;
    bit [7:0]   hold_dec;
    bit [8:0]   ramp_steps;

    bit [2:0]   nxt, hi, lo, watch;
    bit [15:0]  duty_q, hold_left, queued_duty;
    bit [8:0]   ramp_n;
    bit         run, ramp, oc;

    motor_out_t expected_q[$];
    int         errors;
    int         results_seen;

    function new();
        neutral    = RST_NEUTRAL;
        top        = RST_PWM_TOP;
        limit      = RST_CUR_LIMIT;
        start_duty = RST_START_DUTY;
        first_hold = RST_FIRST_HOLD;
        hold_dec   = RST_HOLD_DEC;
        ramp_steps = RST_STEPS;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] v);
        case (idx)
            REG_NEUTRAL:    neutral    = v[15:0];
            REG_PWM_TOP:    top        = v[15:0];
            REG_CUR_LIMIT:  limit      = v[11:0];
            REG_START_DUTY: start_duty = v[15:0];
            REG_FIRST_HOLD: first_hold = v[15:0];
            REG_HOLD_DEC:   hold_dec   = v[7:0];
            REG_STEPS:      ramp_steps = v[8:0];
            default:        ;
        endcase
    endfunction

    // phase order A, B, C = bit 0, 1, 2
    function void next_commutation();
        bit [2:0] s;
        s = (nxt < 3'd6) ? nxt : 3'd0;
        case (s)
            3'd0:    begin hi = 3'b001; lo = 3'b100; watch = 3'b010; end
            3'd1:    begin hi = 3'b010; lo = 3'b100; watch = 3'b001; end
            3'd2:    begin hi = 3'b010; lo = 3'b001; watch = 3'b100; end
            3'd3:    begin hi = 3'b100; lo = 3'b001; watch = 3'b010; end
            3'd4:    begin hi = 3'b100; lo = 3'b010; watch = 3'b001; end
            default: begin hi = 3'b001; lo = 3'b010; watch = 3'b100; end
        endcase
        nxt = (s == LAST_STEP) ? 3'd0 : s + 3'd1;
    endfunction

    // hold shrinks per ramp step, never below one tick
    function bit [15:0] hold_for(int k);
        int cut;
        cut = int'(hold_dec) * k;
        if (cut >= int'(first_hold))
            return 16'd1;
        return 16'(int'(first_hold) - cut);
    endfunction

    function void throttle(bit [15:0] w);
        longint v;
        v = ((longint'(w) - longint'(neutral) + THROTTLE_COUNTS) * longint'(top))
            / THROTTLE_COUNTS;
        if (v < 0)
            v = 0;
        if (v < longint'(top) - longint'(STOP_MARGIN)) begin
            if (run) begin
                duty_q = v[15:0];
            end else begin
                queued_duty = v[15:0];
                run         = 1'b1;
                ramp        = 1'b1;
                ramp_n      = '0;
                duty_q      = start_duty;
                next_commutation();
                hold_left   = hold_for(0);
            end
        end else begin
            run    = 1'b0;
            ramp   = 1'b0;
            duty_q = top;
        end
    endfunction

    function void tick();
        bit [8:0] steps;
        steps = (ramp_steps != '0) ? ramp_steps : 9'd1;
        if (hold_left != '0)
            hold_left--;
        if (hold_left != '0)
            return;
        ramp_n++;
        if (ramp_n >= steps) begin
            ramp   = 1'b0;
            duty_q = queued_duty;
        end else begin
            next_commutation();
            hold_left = hold_for(int'(ramp_n));
        end
    endfunction

    function void take_event(bit [1:0] f, bit [15:0] w, bit [1:0] c, bit [11:0] s);
        motor_out_t e;
        if (f == FUNC_CURRENT) begin
            oc = (s > limit);
            if (oc)
                lo = '0;
        end else if (oc) begin
            // everything but current samples waits out the hold
        end else if (f == FUNC_TICK) begin
            if (ramp)
                tick();
        end else if (f == FUNC_THROTTLE) begin
            if (!ramp)
                throttle(w);
        end else begin
            if (!ramp && (c != 2'd3) && watch[c])
                next_commutation();
        end
        e.high         = hi;
        e.low          = lo;
        e.watch        = watch;
        e.duty         = duty_q;
        if (hi == '0)
            e.step = 3'd0;
        else if (nxt < 3'd6)
            e.step = (nxt == 3'd0) ? LAST_STEP : nxt - 3'd1;
        else
            e.step = LAST_STEP;
        e.moving       = run;
        e.starting     = ramp;
        e.over_current = oc;
        expected_q.push_back(e);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task compare_field(string name, bit [15:0] got, bit [15:0] want);
        if (got != want)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    task check_output(motor_out_t got);
        motor_out_t e;
        if (expected_q.size() == 0) begin
            report("result with no request outstanding");
            return;
        end
        e = expected_q.pop_front();
        compare_field("high_side_on", 16'(got.high), 16'(e.high));
        compare_field("low_side_on", 16'(got.low), 16'(e.low));
        compare_field("watch_mask", 16'(got.watch), 16'(e.watch));
        compare_field("duty", got.duty, e.duty);
        compare_field("step_index", 16'(got.step), 16'(e.step));
        compare_field("moving", 16'(got.moving), 16'(e.moving));
        compare_field("starting", 16'(got.starting), 16'(e.starting));
        compare_field("over_current", 16'(got.over_current), 16'(e.over_current));
        results_seen++;
    endtask
endclass

module six_step_bldc_commutation_control_tb;
    localparam int RANDOM_EVENTS = 1800;
    localparam int PHASES        = 8;
    localparam int CYCLE_LIMIT   = 300000;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [1:0]         func           = FUNC_TICK;
    logic [15:0]        pulse_width    = '0;
    logic [1:0]         comparator     = '0;
    logic [11:0]        current_sample = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [2:0]         high_side_on;
    logic [2:0]         low_side_on;
    logic [2:0]         watch_mask;
    logic [15:0]        duty;
    logic [2:0]         step_index;
    logic               moving;
    logic               starting;
    logic               over_current;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [PDATA_W-1:0] pwdata         = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    commutation_scoreboard sb = new();

    int idle_mode      = 0;   // 0: receiver busy, 1: sender sparse, 2: full rate
    int sent_total     = 0;
    bit want_long_hold = 1'b0;
    int stall_run      = 0;
    int cycles         = 0;

    six_step_bldc_commutation_control u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pulse_width    (pulse_width),
        .comparator     (comparator),
        .current_sample (current_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .high_side_on   (high_side_on),
        .low_side_on    (low_side_on),
        .watch_mask     (watch_mask),
        .duty           (duty),
        .step_index     (step_index),
        .moving         (moving),
        .starting       (starting),
        .over_current   (over_current),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure; a long hold-off fills the pipe
    always @(negedge clk)
    begin
        if (stall_run == 0 && want_long_hold)
        begin
            stall_run      = 80;
            want_long_hold = 1'b0;
        end
        if (stall_run != 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) <
                          ((idle_mode == 0) ? 60 : (idle_mode == 1) ? 23 : 0));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output({high_side_on, low_side_on, watch_mask, duty, step_index,
                             moving, starting, over_current});
    end

    task automatic send_event(bit [1:0] f, bit [15:0] w, bit [1:0] c, bit [11:0] s);
        int gap_pct;
        idle_mode = (sent_total < RANDOM_EVENTS / 3) ? 0 :
                    (sent_total < 2 * RANDOM_EVENTS / 3) ? 1 : 2;
        gap_pct   = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 60 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        pulse_width    <= w;
        comparator     <= c;
        current_sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_event(f, w, c, s);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic random_event();
        int        r;
        int        j;
        int        near;
        bit [1:0]  f;
        bit [1:0]  c;
        bit [15:0] w;
        bit [11:0] s;
        r    = $urandom_range(0, 99);
        j    = $urandom_range(0, 7000);
        // widths just below neutral keep the motor running
        near = int'(sb.neutral) + j - 6800;
        if (near < 0)
            near = 0;
        else if (near > 65535)
            near = 65535;
        case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2:    w = 16'($urandom_range(0, 65535));
            default: w = near[15:0];
        endcase
        c = 2'($urandom_range(0, 3));
        if (sb.watch != '0 && $urandom_range(0, 99) < 70)
            c = sb.watch[0] ? 2'd0 : sb.watch[1] ? 2'd1 : 2'd2;
        if ($urandom_range(0, 99) < 70)
            s = 12'($urandom_range(0, int'(sb.limit)));
        else
            s = 12'($urandom_range(0, 4095));
        f = 2'($urandom_range(0, 3));
        if (sb.oc)
        begin
            if (r < 60)
                f = FUNC_CURRENT;
        end
        else if (sb.ramp)
        begin
            if (r < 80)
                f = FUNC_TICK;
        end
        else if (sb.run)
        begin
            if (r < 55)
                f = FUNC_COMPARE;
            else if (r < 70)
                f = FUNC_THROTTLE;
        end
        else if (r < 50)
            f = FUNC_THROTTLE;
        send_event(f, w, c, s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(bit [15:0] nw, bit [15:0] tp, bit [11:0] lim,
                                 bit [15:0] sd, bit [15:0] fh, bit [7:0] dec,
                                 bit [8:0] st);
        write_reg(REG_NEUTRAL, 32'(nw));
        write_reg(REG_PWM_TOP, 32'(tp));
        write_reg(REG_CUR_LIMIT, 32'(lim));
        write_reg(REG_START_DUTY, 32'(sd));
        write_reg(REG_FIRST_HOLD, 32'(fh));
        write_reg(REG_HOLD_DEC, 32'(dec));
        write_reg(REG_STEPS, 32'(st));
    endtask

    initial
    begin
        int n;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // power-up defaults: only widths that keep the motor stopped
        send_event(FUNC_TICK, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_COMPARE, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_COMPARE, 16'hFFFF, 2'd3, 12'hFFF);
        send_event(FUNC_CURRENT, 16'd0, 2'd0, 12'hFFF);
        send_event(FUNC_THROTTLE, 16'd2900, 2'd1, 12'd0);
        send_event(FUNC_TICK, 16'd0, 2'd2, 12'd0);
        send_event(FUNC_CURRENT, 16'd0, 2'd0, RST_CUR_LIMIT);
        send_event(FUNC_THROTTLE, 16'hFFFF, 2'd0, 12'd0);
        send_event(FUNC_THROTTLE, 16'd6000, 2'd0, 12'd0);
        drain();

        // short ramp: start, ignored events, trip and release mid-ramp
        load_settings(16'd3000, 16'd1200, 12'd3000, 16'd200, 16'd3, 8'd1, 9'd4);
        send_event(FUNC_THROTTLE, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_THROTTLE, 16'd1000, 2'd0, 12'd0);
        send_event(FUNC_COMPARE, 16'd0, 2'd1, 12'd0);
        send_event(FUNC_TICK, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_CURRENT, 16'd0, 2'd0, 12'd4000);
        send_event(FUNC_TICK, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_CURRENT, 16'd0, 2'd0, 12'd0);
        repeat (6) send_event(FUNC_TICK, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_COMPARE, 16'd0, 2'd0, 12'd0);
        send_event(FUNC_COMPARE, 16'd0, 2'd1, 12'd0);
        send_event(FUNC_COMPARE, 16'd0, 2'd2, 12'd0);
        send_event(FUNC_THROTTLE, 16'd2900, 2'd0, 12'd0);
        send_event(FUNC_THROTTLE, 16'hFFFF, 2'd0, 12'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1: load_settings(16'd0, 16'd64, 12'd0, 16'd0, 16'd1, 8'd0, 9'd1);
                    2: load_settings(16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF, 16'd40,
                                     8'hFF, 9'h1FF);
                    PHASES - 1:
                        load_settings(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(64, 65535)),
                                      12'($urandom_range(0, 4095)),
                                      16'($urandom_range(0, 65535)),
                                      16'hFFFF,
                                      8'($urandom_range(0, 255)),
                                      9'($urandom_range(1, 511)));
                    default:
                        load_settings(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 1) ? $urandom_range(64, 2000)
                                                               : $urandom_range(64, 65535)),
                                      12'($urandom_range(0, 4095)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(1, 30)),
                                      8'($urandom_range(0, 3)),
                                      9'($urandom_range(1, 24)));
                endcase
            end
            n = 0;
            while (n < RANDOM_EVENTS / PHASES)
            begin
                if (n == 100 && (p == 0 || p == PHASES - 2))
                    want_long_hold = 1'b1;
                random_event();
                n++;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
